>>> hw/rtl/text_encoding_detector_assert.svh
// ----------------------------------------------------------------------------
// text encoding detector assertion macros
// shared property forms for the detector checks
// ----------------------------------------------------------------------------
`ifndef TEXT_ENCODING_DETECTOR_ASSERT_SVH
`define TEXT_ENCODING_DETECTOR_ASSERT_SVH

// same-cycle implication, sampled on clk, quiet in reset
`define TED_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, sampled on clk, quiet in reset
`define TED_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hw/rtl/ted_pkg.sv
// ----------------------------------------------------------------------------
// ted_pkg
// codes, stage type and utf-8 step functions for the encoding detector
// ----------------------------------------------------------------------------
package ted_pkg;

    typedef logic [3:0] seq_t;
    typedef logic [1:0] phase_t;
    typedef logic [2:0] enc_class_t;

    typedef struct packed {
        logic       valid;
        logic       end_of_text;
        logic [7:0] text_byte;
    } ted_stage_t;

    localparam enc_class_t CLASS_ANSI     = 3'd0;
    localparam enc_class_t CLASS_UTF8     = 3'd1;
    localparam enc_class_t CLASS_UTF8_BOM = 3'd2;
    localparam enc_class_t CLASS_UTF16    = 3'd3;
    localparam enc_class_t CLASS_UTF32    = 3'd4;

    localparam phase_t PH_SCAN  = 2'd0;
    localparam phase_t PH_CHECK = 2'd1;
    localparam phase_t PH_ANSI  = 2'd2;
    localparam phase_t PH_UTF8  = 2'd3;

    localparam seq_t SEQ_IDLE    = 4'd0;
    localparam seq_t SEQ_ONE     = 4'd1;
    localparam seq_t SEQ_TWO     = 4'd2;
    localparam seq_t SEQ_AFT_E0  = 4'd3;
    localparam seq_t SEQ_AFT_ED  = 4'd4;
    localparam seq_t SEQ_AFT_F0  = 4'd5;
    localparam seq_t SEQ_AFT_F1  = 4'd6;
    localparam seq_t SEQ_AFT_F4  = 4'd7;
    localparam seq_t SEQ_BAD     = 4'd15;

    localparam logic [7:0] BYTE_ZERO = 8'h00;
    localparam logic [7:0] BYTE_EF   = 8'hEF;
    localparam logic [7:0] BYTE_BB   = 8'hBB;
    localparam logic [7:0] BYTE_BF   = 8'hBF;
    localparam logic [7:0] BYTE_FE   = 8'hFE;
    localparam logic [7:0] BYTE_FF   = 8'hFF;

    function automatic logic is_plain_ascii(input logic [7:0] b);
        return (b == 8'h09) || (b == 8'h0A) || (b == 8'h0D) || (b >= 8'h20 && b <= 8'h7E);
    endfunction

    function automatic seq_t lead_state(input logic [7:0] b);
        seq_t s;
        priority if (b >= 8'hC2 && b <= 8'hDF) s = SEQ_ONE;
        else if (b == 8'hE0) s = SEQ_AFT_E0;
        else if (b == 8'hED) s = SEQ_AFT_ED;
        else if (b >= 8'hE1 && b <= 8'hEF) s = SEQ_TWO;
        else if (b == 8'hF0) s = SEQ_AFT_F0;
        else if (b >= 8'hF1 && b <= 8'hF3) s = SEQ_AFT_F1;
        else if (b == 8'hF4) s = SEQ_AFT_F4;
        else s = SEQ_BAD;
        return s;
    endfunction

    function automatic seq_t cont_state(input seq_t s, input logic [7:0] b);
        logic [7:0] lo;
        logic [7:0] hi;
        seq_t       nxt;
        logic       known;
        lo    = 8'h80;
        hi    = 8'hBF;
        nxt   = SEQ_BAD;
        known = 1'b1;
        unique case (s)
            SEQ_ONE:    nxt = SEQ_IDLE;
            SEQ_TWO:    nxt = SEQ_ONE;
            SEQ_AFT_E0:
            begin
                lo  = 8'hA0;
                nxt = SEQ_ONE;
            end
            SEQ_AFT_ED:
            begin
                hi  = 8'h9F;
                nxt = SEQ_ONE;
            end
            SEQ_AFT_F0:
            begin
                lo  = 8'h90;
                nxt = SEQ_TWO;
            end
            SEQ_AFT_F1: nxt = SEQ_TWO;
            SEQ_AFT_F4:
            begin
                hi  = 8'h8F;
                nxt = SEQ_TWO;
            end
            default:    known = 1'b0;
        endcase
        return (known && b >= lo && b <= hi) ? nxt : SEQ_BAD;
    endfunction

endpackage

>>> hw/rtl/ted_byte_if.sv
// ----------------------------------------------------------------------------
// ted_byte_if
// text byte channel: one byte of text and its end-of-text flag per word
// ----------------------------------------------------------------------------
interface ted_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] text_byte;
    logic       end_of_text;

    modport source (output valid, output text_byte, output end_of_text, input ready);
    modport sink   (input valid, input text_byte, input end_of_text, output ready);
endinterface

>>> hw/rtl/ted_class_if.sv
// ----------------------------------------------------------------------------
// ted_class_if
// encoding class channel: one detected class per word
// ----------------------------------------------------------------------------
interface ted_class_if;
    logic       valid;
    logic       ready;
    logic [2:0] encoding_class;

    modport source (output valid, output encoding_class, input ready);
    modport sink   (input valid, input encoding_class, output ready);
endinterface

>>> hw/rtl/ted_in_stage.sv
// ----------------------------------------------------------------------------
// ted_in_stage
// input register for the text byte channel
// ----------------------------------------------------------------------------
module ted_in_stage
    import ted_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    ted_byte_if.sink   text_in,
    input  logic       advance,
    output ted_stage_t stage
);

    logic       valid_reg;
    logic       valid_next;
    logic       eot_reg;
    logic [7:0] byte_reg;
    logic       take;

    assign text_in.ready = !valid_reg || advance;
    assign take          = text_in.valid && text_in.ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (take)
        begin
            valid_next = 1'b1;
        end
        else if (advance)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            eot_reg  <= text_in.end_of_text;
            byte_reg <= text_in.text_byte;
        end
    end

    assign stage = '{valid: valid_reg, end_of_text: eot_reg, text_byte: byte_reg};

endmodule

>>> hw/rtl/ted_core.sv
// ----------------------------------------------------------------------------
// ted_core
// header capture, plain and marked utf-8 scans, and the class decision
// ----------------------------------------------------------------------------
module ted_core
    import ted_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  ted_stage_t stage,
    input  logic       step,
    output enc_class_t enc_class
);

    logic [7:0] hdr_reg  [4];
    logic [7:0] hdr_next [4];
    logic [2:0] pos_reg;
    logic [2:0] pos_next;
    phase_t     phase_reg;
    phase_t     phase_next;
    seq_t       pseq_reg;
    seq_t       pseq_next;
    seq_t       mseq_reg;
    seq_t       mseq_next;
    logic       minv_reg;
    logic       minv_next;
    logic       zero_reg;
    logic       zero_next;
    logic [7:0] b;
    seq_t       plead;
    seq_t       pcont;
    seq_t       mstep;

    assign b     = stage.text_byte;
    assign plead = lead_state(b);
    assign pcont = cont_state(pseq_reg, b);
    assign mstep = (mseq_reg == SEQ_IDLE) ? lead_state(b) : cont_state(mseq_reg, b);

    // state after this byte, before any end-of-text clear
    always_comb
    begin
        for (int i = 0; i < 4; i++)
        begin
            hdr_next[i] = hdr_reg[i];
            if (!pos_reg[2] && pos_reg[1:0] == 2'(i))
            begin
                hdr_next[i] = b;
            end
        end
        pos_next   = pos_reg[2] ? pos_reg : pos_reg + 3'd1;
        phase_next = phase_reg;
        pseq_next  = pseq_reg;
        mseq_next  = mseq_reg;
        minv_next  = minv_reg;
        zero_next  = zero_reg;
        if (!zero_reg)
        begin
            zero_next = (b == BYTE_ZERO);
            // plain scan
            unique case (phase_reg)
                PH_SCAN:
                begin
                    if (b == BYTE_ZERO || (!is_plain_ascii(b) && plead == SEQ_BAD))
                    begin
                        phase_next = PH_ANSI;
                    end
                    else if (!is_plain_ascii(b))
                    begin
                        pseq_next  = plead;
                        phase_next = PH_CHECK;
                    end
                end
                PH_CHECK:
                begin
                    if (pcont == SEQ_BAD)
                    begin
                        phase_next = PH_ANSI;
                        pseq_next  = SEQ_IDLE;
                    end
                    else
                    begin
                        pseq_next = pcont;
                        if (pcont == SEQ_IDLE)
                        begin
                            phase_next = PH_UTF8;
                        end
                    end
                end
                default:
                begin
                end
            endcase
            // marked scan from the fourth byte on
            if ((pos_reg >= 3'd3) && !minv_reg &&
                !(mseq_reg == SEQ_IDLE && (b == BYTE_ZERO || is_plain_ascii(b))))
            begin
                if (mstep == SEQ_BAD)
                begin
                    minv_next = 1'b1;
                    mseq_next = SEQ_IDLE;
                end
                else
                begin
                    mseq_next = mstep;
                end
            end
        end
    end

    always_comb
    begin
        if ((hdr_next[0] == BYTE_ZERO && hdr_next[1] == BYTE_ZERO &&
             hdr_next[2] == BYTE_FE && hdr_next[3] == BYTE_FF) ||
            (hdr_next[0] == BYTE_FF && hdr_next[1] == BYTE_FE &&
             hdr_next[2] == BYTE_ZERO && hdr_next[3] == BYTE_ZERO))
        begin
            enc_class = CLASS_UTF32;
        end
        else if ((hdr_next[0] == BYTE_FE && hdr_next[1] == BYTE_FF) ||
                 (hdr_next[0] == BYTE_FF && hdr_next[1] == BYTE_FE))
        begin
            enc_class = CLASS_UTF16;
        end
        else if (hdr_next[0] == BYTE_EF && hdr_next[1] == BYTE_BB &&
                 hdr_next[2] == BYTE_BF && !minv_next && mseq_next == SEQ_IDLE)
        begin
            enc_class = CLASS_UTF8_BOM;
        end
        else
        begin
            enc_class = (phase_next == PH_UTF8) ? CLASS_UTF8 : CLASS_ANSI;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 4; i++)
            begin
                hdr_reg[i] <= BYTE_ZERO;
            end
            pos_reg   <= 3'd0;
            phase_reg <= PH_SCAN;
            pseq_reg  <= SEQ_IDLE;
            mseq_reg  <= SEQ_IDLE;
            minv_reg  <= 1'b0;
            zero_reg  <= 1'b0;
        end
        else if (step)
        begin
            if (stage.end_of_text)
            begin
                // text done, back to reset values for the next one
                for (int i = 0; i < 4; i++)
                begin
                    hdr_reg[i] <= BYTE_ZERO;
                end
                pos_reg   <= 3'd0;
                phase_reg <= PH_SCAN;
                pseq_reg  <= SEQ_IDLE;
                mseq_reg  <= SEQ_IDLE;
                minv_reg  <= 1'b0;
                zero_reg  <= 1'b0;
            end
            else
            begin
                for (int i = 0; i < 4; i++)
                begin
                    hdr_reg[i] <= hdr_next[i];
                end
                pos_reg   <= pos_next;
                phase_reg <= phase_next;
                pseq_reg  <= pseq_next;
                mseq_reg  <= mseq_next;
                minv_reg  <= minv_next;
                zero_reg  <= zero_next;
            end
        end
    end

endmodule

>>> hw/rtl/text_encoding_detector.sv
// ----------------------------------------------------------------------------
// text_encoding_detector
// byte-order-mark check and strict utf-8 scan giving one class per text
//
//   channel    dir  word
//   text_in    in   text_byte[7:0], end_of_text
//   class_out  out  encoding_class[2:0], one word per end_of_text byte
//
// one byte per cycle while no final byte is blocked; input register, scan logic,
// result register, so a class leaves through both registers after its final byte is taken
// bytes keep flowing while a class waits; only a final byte waits for the
// result register to empty
// reset clears all scan state; each text also returns it to reset values
// ----------------------------------------------------------------------------
`include "text_encoding_detector_assert.svh"

module text_encoding_detector
    import ted_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    ted_byte_if.sink    text_in,
    ted_class_if.source class_out
);

    ted_stage_t stage;
    logic       advance;
    logic       step;
    enc_class_t enc_class;
    logic       res_valid_reg;
    logic       res_valid_next;
    enc_class_t res_class_reg;
    logic       emit;

    assign advance = !stage.end_of_text || !res_valid_reg || class_out.ready;
    assign step    = stage.valid && advance;
    assign emit    = step && stage.end_of_text;

    ted_in_stage u_in_stage (
        .clk     (clk),
        .rst_n   (rst_n),
        .text_in (text_in),
        .advance (advance),
        .stage   (stage)
    );

    ted_core u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .stage     (stage),
        .step      (step),
        .enc_class (enc_class)
    );

    always_comb
    begin
        res_valid_next = res_valid_reg;
        if (emit)
        begin
            res_valid_next = 1'b1;
        end
        else if (class_out.ready)
        begin
            res_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else
        begin
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            res_class_reg <= enc_class;
        end
    end

    assign class_out.valid          = res_valid_reg;
    assign class_out.encoding_class = res_class_reg;

    `TED_ASSERT_NOW(a_ready_low_only_on_blocked_final, !text_in.ready, stage.valid && stage.end_of_text && res_valid_reg && !class_out.ready, "input stalled without a blocked final byte")
    `TED_ASSERT_NEXT(a_final_byte_gives_class, emit, res_valid_reg, "final byte did not load a class")
    `TED_ASSERT_NEXT(a_blocked_final_held, stage.valid && stage.end_of_text && !advance, stage.valid && stage.end_of_text, "blocked final byte dropped")

endmodule

>>> tb/tb.sv
// ----------------------------------------------------------------------------
// tb: text encoding detector testbench
// streams texts byte by byte through the detector, mark-led and plain, valid
// and broken utf-8, with random gaps on both channels, and compares every
// returned class against a cycle-free model of the mark check and both scans
// ----------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import ted_pkg::*;

    localparam int unsigned TARGET_BYTES = 1550;
    localparam int unsigned QUIET_FROM   = 1350;
    localparam int unsigned CYCLE_LIMIT  = 400000;

    class encoding_tracker;
        logic [7:0]  head_bytes [4];
        int unsigned taken;
        phase_t      plain_phase;
        seq_t        plain_seq;
        seq_t        marked_seq;
        bit          marked_bad;
        bit          zero_seen;
        enc_class_t  pending_classes [$];
        int unsigned mismatches;
        int unsigned compared;
        int unsigned per_class [5];

        function new();
            restart();
        endfunction

        function void restart();
            foreach (head_bytes[i])
                head_bytes[i] = BYTE_ZERO;
            taken       = 0;
            plain_phase = PH_SCAN;
            plain_seq   = SEQ_IDLE;
            marked_seq  = SEQ_IDLE;
            marked_bad  = 1'b0;
            zero_seen   = 1'b0;
        endfunction

        task report(string msg);
            $display("tb: mismatch at %0t: %s", $realtime, msg);
            mismatches++;
        endtask

        function bit is_text_char(logic [7:0] b);
            return b == 8'h09 || b == 8'h0A || b == 8'h0D || (b >= 8'h20 && b < 8'h7F);
        endfunction

        function seq_t lead_of(logic [7:0] b);
            if (b < 8'hC2 || b > 8'hF4)
                return SEQ_BAD;
            if (b <= 8'hDF)
                return SEQ_ONE;
            case (b)
                8'hE0:   return SEQ_AFT_E0;
                8'hED:   return SEQ_AFT_ED;
                8'hF0:   return SEQ_AFT_F0;
                8'hF4:   return SEQ_AFT_F4;
                default: return (b <= 8'hEF) ? SEQ_TWO : SEQ_AFT_F1;
            endcase
        endfunction

        function seq_t cont_of(seq_t s, logic [7:0] b);
            logic [7:0] lo;
            logic [7:0] hi;
            seq_t       nxt;
            lo = 8'h80;
            hi = 8'hBF;
            case (s)
                SEQ_ONE:                             nxt = SEQ_IDLE;
                SEQ_TWO, SEQ_AFT_E0, SEQ_AFT_ED:     nxt = SEQ_ONE;
                SEQ_AFT_F0, SEQ_AFT_F1, SEQ_AFT_F4:  nxt = SEQ_TWO;
                default:                             return SEQ_BAD;
            endcase
            if (s == SEQ_AFT_E0)
                lo = 8'hA0;
            if (s == SEQ_AFT_F0)
                lo = 8'h90;
            if (s == SEQ_AFT_ED)
                hi = 8'h9F;
            if (s == SEQ_AFT_F4)
                hi = 8'h8F;
            return (b >= lo && b <= hi) ? nxt : SEQ_BAD;
        endfunction

        function void plain_step(logic [7:0] b);
            seq_t s;
            case (plain_phase)
                PH_SCAN:
                begin
                    if (b == BYTE_ZERO)
                        plain_phase = PH_ANSI;
                    else if (!is_text_char(b))
                    begin
                        s = lead_of(b);
                        if (s == SEQ_BAD)
                            plain_phase = PH_ANSI;
                        else
                        begin
                            plain_seq   = s;
                            plain_phase = PH_CHECK;
                        end
                    end
                end
                PH_CHECK:
                begin
                    s = cont_of(plain_seq, b);
                    if (s == SEQ_BAD)
                        plain_phase = PH_ANSI;
                    else if (s == SEQ_IDLE)
                        plain_phase = PH_UTF8;
                    plain_seq = (s == SEQ_BAD) ? SEQ_IDLE : s;
                end
                default: ;
            endcase
        endfunction

        function void marked_step(logic [7:0] b);
            seq_t s;
            if (marked_bad)
                return;
            if (marked_seq == SEQ_IDLE)
            begin
                if (b == BYTE_ZERO || is_text_char(b))
                    return;
                s = lead_of(b);
            end
            else
                s = cont_of(marked_seq, b);
            if (s == SEQ_BAD)
            begin
                marked_bad = 1'b1;
                marked_seq = SEQ_IDLE;
            end
            else
                marked_seq = s;
        endfunction

        function enc_class_t class_of_text();
            if ((head_bytes[0] == BYTE_ZERO && head_bytes[1] == BYTE_ZERO &&
                 head_bytes[2] == BYTE_FE && head_bytes[3] == BYTE_FF) ||
                (head_bytes[0] == BYTE_FF && head_bytes[1] == BYTE_FE &&
                 head_bytes[2] == BYTE_ZERO && head_bytes[3] == BYTE_ZERO))
                return CLASS_UTF32;
            if ((head_bytes[0] == BYTE_FE && head_bytes[1] == BYTE_FF) ||
                (head_bytes[0] == BYTE_FF && head_bytes[1] == BYTE_FE))
                return CLASS_UTF16;
            if (head_bytes[0] == BYTE_EF && head_bytes[1] == BYTE_BB &&
                head_bytes[2] == BYTE_BF && !marked_bad && marked_seq == SEQ_IDLE)
                return CLASS_UTF8_BOM;
            return (plain_phase == PH_UTF8) ? CLASS_UTF8 : CLASS_ANSI;
        endfunction

        function void take_byte(logic [7:0] b, logic is_last);
            int unsigned pos;
            pos = taken;
            if (pos < 4)
            begin
                head_bytes[pos] = b;
                taken++;
            end
            if (!zero_seen)
            begin
                plain_step(b);
                if (pos >= 3)
                    marked_step(b);
                if (b == BYTE_ZERO)
                    zero_seen = 1'b1;
            end
            if (is_last)
            begin
                pending_classes.push_back(class_of_text());
                restart();
            end
        endfunction

        task check_class(enc_class_t got);
            enc_class_t want;
            compared++;
            if (got < 5)
                per_class[got]++;
            if (pending_classes.size() == 0)
            begin
                report($sformatf("class %0d with no text pending", got));
                return;
            end
            want = pending_classes.pop_front();
            if (got !== want)
                report($sformatf("encoding_class %0d, expected %0d", got, want));
        endtask

        function int unsigned pending();
            return pending_classes.size();
        endfunction
    endclass

    logic clk;
    logic rst_n;

    ted_byte_if  text_in ();
    ted_class_if class_out ();

    text_encoding_detector uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .text_in   (text_in),
        .class_out (class_out)
    );

    encoding_tracker tracker = new();

    logic [7:0]  text_bytes [$];
    int unsigned bytes_sent;
    int unsigned texts_sent;
    int unsigned cycle_count;
    bit          quiet;
    bit          lively;

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    initial
    begin
        rst_n = 1'b0;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
    end

    always @(posedge clk)
    begin
        if (text_in.valid && text_in.ready)
            tracker.take_byte(text_in.text_byte, text_in.end_of_text);
        if (class_out.valid && class_out.ready)
            tracker.check_class(class_out.encoding_class);
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("tb: errors");
            $finish;
        end
    end

    initial
    begin
        int stall;
        stall           = 0;
        class_out.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (stall > 0)
            begin
                class_out.ready = 1'b0;
                stall--;
            end
            else if (!quiet && lively && $urandom_range(0, 5) == 0)
            begin
                class_out.ready = 1'b0;
                stall = $urandom_range(1, 14) - 1;
            end
            else
                class_out.ready = 1'b1;
        end
    end

    task automatic send_byte(input logic [7:0] b, input logic is_last);
        int gap;
        if (!quiet && lively && $urandom_range(0, 7) == 0)
        begin
            gap = $urandom_range(1, 14);
            text_in.valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        text_in.valid       = 1'b1;
        text_in.text_byte   = b;
        text_in.end_of_text = is_last;
        do
            @(posedge clk);
        while (!text_in.ready);
        bytes_sent++;
        @(negedge clk);
    endtask

    task automatic send_text();
        foreach (text_bytes[i])
            send_byte(text_bytes[i], i == text_bytes.size() - 1);
        texts_sent++;
        if (bytes_sent >= QUIET_FROM)
            quiet = 1'b1;
        lively = $urandom_range(0, 3) != 0;
    endtask

    task automatic add_ascii();
        int n;
        n = $urandom_range(1, 5);
        repeat (n)
        begin
            case ($urandom_range(0, 9))
                0:       text_bytes.push_back(8'h09);
                1:       text_bytes.push_back(8'h0A);
                2:       text_bytes.push_back(8'h0D);
                default: text_bytes.push_back(8'($urandom_range(8'h20, 8'h7E)));
            endcase
        end
    endtask

    // mode 0 well formed, 1 second byte out of range or random, 2 cut short
    task automatic add_char(input int mode);
        logic [7:0] lead;
        logic [7:0] lo;
        logic [7:0] hi;
        logic [7:0] second;
        int         conts;
        int         keep;
        lo = 8'h80;
        hi = 8'hBF;
        case ($urandom_range(0, 6))
            0:
            begin
                lead  = 8'($urandom_range(8'hC2, 8'hDF));
                conts = 1;
            end
            1:
            begin
                lead  = 8'hE0;
                lo    = 8'hA0;
                conts = 2;
            end
            2:
            begin
                lead  = 8'hED;
                hi    = 8'h9F;
                conts = 2;
            end
            3:
            begin
                lead  = $urandom_range(0, 1) ? 8'($urandom_range(8'hE1, 8'hEC))
                                             : 8'($urandom_range(8'hEE, 8'hEF));
                conts = 2;
            end
            4:
            begin
                lead  = 8'hF0;
                lo    = 8'h90;
                conts = 3;
            end
            5:
            begin
                lead  = 8'($urandom_range(8'hF1, 8'hF3));
                conts = 3;
            end
            default:
            begin
                lead  = 8'hF4;
                hi    = 8'h8F;
                conts = 3;
            end
        endcase
        second = 8'($urandom_range(lo, hi));
        if (mode == 1)
        begin
            if ($urandom_range(0, 1) == 0)
                second = 8'($urandom_range(0, 255));
            else if (lo > 8'h80)
                second = 8'($urandom_range(8'h80, lo - 1));
            else if (hi < 8'hBF)
                second = 8'($urandom_range(hi + 1, 8'hBF));
            else
                second = $urandom_range(0, 1) ? 8'($urandom_range(0, 8'h7F))
                                              : 8'($urandom_range(8'hC0, 8'hFF));
        end
        keep = (mode == 2) ? $urandom_range(0, conts - 1) : conts;
        text_bytes.push_back(lead);
        if (keep > 0)
            text_bytes.push_back(second);
        for (int i = 1; i < keep; i++)
            text_bytes.push_back(8'($urandom_range(8'h80, 8'hBF)));
    endtask

    task automatic add_body();
        int         n;
        logic [7:0] b;
        n = $urandom_range(0, 6);
        repeat (n)
        begin
            case ($urandom_range(0, 15))
                0, 1, 2, 3, 4, 5:  add_ascii();
                6, 7, 8, 9, 10:    add_char(0);
                11:                add_char(2);
                12:                add_char(1);
                13:                text_bytes.push_back(BYTE_ZERO);
                14:
                begin
                    b = 8'($urandom_range(1, 8'h1F));
                    if (b == 8'h09 || b == 8'h0A || b == 8'h0D)
                        b = 8'h7F;
                    text_bytes.push_back(b);
                end
                default:           text_bytes.push_back(8'($urandom_range(0, 255)));
            endcase
        end
    endtask

    function automatic logic [7:0] mark_like_byte();
        case ($urandom_range(0, 6))
            0:       return BYTE_ZERO;
            1:       return BYTE_EF;
            2:       return BYTE_BB;
            3:       return BYTE_BF;
            4:       return BYTE_FE;
            5:       return BYTE_FF;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    task automatic build_text();
        int n;
        text_bytes.delete();
        case ($urandom_range(0, 19))
            0:
            begin
                if ($urandom_range(0, 1))
                    text_bytes = '{BYTE_ZERO, BYTE_ZERO, BYTE_FE, BYTE_FF};
                else
                    text_bytes = '{BYTE_FF, BYTE_FE, BYTE_ZERO, BYTE_ZERO};
                add_body();
            end
            1:
            begin
                if ($urandom_range(0, 1))
                    text_bytes = '{BYTE_FE, BYTE_FF};
                else
                    text_bytes = '{BYTE_FF, BYTE_FE};
                add_body();
            end
            2, 3, 4, 5:
            begin
                text_bytes = '{BYTE_EF, BYTE_BB, BYTE_BF};
                add_body();
            end
            6:
            begin
                n = $urandom_range(1, 8);
                repeat (n)
                    text_bytes.push_back(8'($urandom_range(0, 255)));
            end
            7:
            begin
                n = $urandom_range(1, 4);
                repeat (n)
                    text_bytes.push_back(mark_like_byte());
                if ($urandom_range(0, 1))
                    add_body();
            end
            default:
            begin
                if ($urandom_range(0, 1))
                    add_ascii();
                add_body();
            end
        endcase
        if (text_bytes.size() == 0)
            add_ascii();
    endtask

    initial
    begin
        text_in.valid       = 1'b0;
        text_in.text_byte   = 8'h00;
        text_in.end_of_text = 1'b0;
        bytes_sent          = 0;
        texts_sent          = 0;
        quiet               = 1'b0;
        lively              = 1'b1;
        @(posedge rst_n);
        @(negedge clk);

        text_bytes = '{BYTE_ZERO, BYTE_ZERO, BYTE_FE, BYTE_FF};
        send_text();
        text_bytes = '{BYTE_FF, BYTE_FE};
        send_text();
        text_bytes = '{BYTE_FE, BYTE_FF, 8'h41};
        send_text();
        text_bytes = '{BYTE_EF, BYTE_BB, BYTE_BF, 8'hC3, 8'hA9};
        send_text();
        text_bytes = '{8'hE0, 8'hA0, 8'h80};
        send_text();
        text_bytes = '{8'hF4, 8'h90};
        send_text();
        text_bytes = '{8'h41, BYTE_ZERO, 8'hC3};
        send_text();
        text_bytes = '{8'h7F};
        send_text();
        text_bytes = '{BYTE_FF};
        send_text();

        while (bytes_sent < TARGET_BYTES)
        begin
            build_text();
            send_text();
        end
        text_in.valid       = 1'b0;
        text_in.end_of_text = 1'b0;

        while (tracker.pending() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);

        $display("tb: %0d bytes in %0d texts, %0d classes compared", bytes_sent,
                 texts_sent, tracker.compared);
        $display("tb: ansi %0d, utf-8 %0d, utf-8 marked %0d, utf-16 %0d, utf-32 %0d",
                 tracker.per_class[CLASS_ANSI], tracker.per_class[CLASS_UTF8],
                 tracker.per_class[CLASS_UTF8_BOM], tracker.per_class[CLASS_UTF16],
                 tracker.per_class[CLASS_UTF32]);
        if (tracker.mismatches == 0)
            $display("tb: clean");
        else
            $display("tb: errors");
        $finish;
    end
endmodule

>>> files.f
+incdir+hw/rtl
hw/rtl/ted_pkg.sv
hw/rtl/ted_byte_if.sv
hw/rtl/ted_class_if.sv
hw/rtl/ted_in_stage.sv
hw/rtl/ted_core.sv
hw/rtl/text_encoding_detector.sv
tb/tb.sv
